### src/laq_pkg.sv
// Shared constants, codes and types for the linear array queue with search.
`default_nettype none

package laq_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int CAP_W  = 5;
	localparam int CMD_W  = 2;
	localparam int STAT_W = 3;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

	// Commands
	localparam logic [CMD_W-1:0] CMD_ENQ  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DEQ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SRCH = 2'd2;
	localparam logic [CMD_W-1:0] CMD_DISP = 2'd3;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
	localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd4;

	// Request from the sequencer to the entry store
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} mem_req_t;

endpackage

`default_nettype wire

### src/laq_mem.sv
// Entry store: one write port and one registered read port.
`default_nettype none

module laq_mem
	import laq_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic [DATA_W-1:0]      rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write one slot
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
	end

	// Read one slot, registered
	always_ff @(posedge clk) begin
		rdata <= mem_q[req.raddr];
	end

endmodule

`default_nettype wire

### src/laq_count.sv
// Compare unit with a match counter, stepped on each entry of a search walk but the last.
`default_nettype none

module laq_count
	import laq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              clr,
	input  wire logic              en,
	input  wire logic [DATA_W-1:0] entry,
	input  wire logic [DATA_W-1:0] key,
	output logic                   hit,
	output logic [CNT_W-1:0]       count_q
);

	// Compare the entry on the read port against the key
	assign hit = (entry == key);

	// Accumulate hits over the walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clr) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_q + CNT_W'(hit);
		end
	end

endmodule

`default_nettype wire

### src/laq_seq.sv
// Command sequencer: queue pointers, capacity register, walk control and result register.
`default_nettype none

module laq_seq
	import laq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [DATA_W-1:0] s_tdata,
	input  wire logic [CMD_W-1:0]  s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [DATA_W-1:0]      out_data,
	output logic [CNT_W-1:0]       out_count,
	output logic [STAT_W-1:0]      out_status,
	output logic                   out_last,
	output mem_req_t               mem_req,
	input  wire logic [DATA_W-1:0] rdata
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic              state_q, state_n;
	logic [CMD_W-1:0]  cmd_q, cmd_n;
	logic [DATA_W-1:0] key_q, key_n;
	logic [IDX_W-1:0]  ptr_q, ptr_n;
	logic [IDX_W-1:0]  head_q, head_n;
	logic [IDX_W-1:0]  tail_q, tail_n;
	logic              empty_q, empty_n;
	logic [CAP_W-1:0]  cap_q;

	logic              m_tvalid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [CNT_W-1:0]  out_count_q;
	logic [STAT_W-1:0] out_status_q;
	logic              out_last_q;

	logic              load;
	logic [DATA_W-1:0] ld_data;
	logic [CNT_W-1:0]  ld_count;
	logic [STAT_W-1:0] ld_status;
	logic              ld_last;

	logic              out_free;
	logic [CNT_W-1:0]  usable;
	logic [CNT_W-1:0]  tail_inc;
	logic [CNT_W-1:0]  total;
	logic              cnt_clr;
	logic              cnt_en;
	logic              hit;
	logic [CNT_W-1:0]  count_q;

	laq_count u_count (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (cnt_clr),
		.en      (cnt_en),
		.entry   (rdata),
		.key     (key_q),
		.hit     (hit),
		.count_q (count_q)
	);

	assign out_free = !m_tvalid_q || m_tready;
	assign tail_inc = {1'b0, tail_q} + CNT_W'(1);
	assign total    = count_q + CNT_W'(hit);

	// Clamp capacity to between one and the built depth
	always_comb begin
		priority if (cap_q == '0) begin
			usable = CNT_W'(1);
		end else if (cap_q > CAP_W'(DEPTH)) begin
			usable = CNT_W'(DEPTH);
		end else begin
			usable = CNT_W'(cap_q);
		end
	end

	// Sequence one command
	always_comb begin
		state_n   = state_q;
		cmd_n     = cmd_q;
		key_n     = key_q;
		ptr_n     = ptr_q;
		head_n    = head_q;
		tail_n    = tail_q;
		empty_n   = empty_q;
		load      = 1'b0;
		ld_data   = '0;
		ld_count  = '0;
		ld_status = STAT_OK;
		ld_last   = 1'b1;
		cnt_clr   = 1'b0;
		cnt_en    = 1'b0;
		s_tready  = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = '0;
		mem_req.wdata = key_q;

		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd_n   = s_tuser;
					key_n   = s_tdata;
					ptr_n   = head_q;
					cnt_clr = 1'b1;
					state_n = ST_BUSY;
				end
			end
			ST_BUSY: begin
				unique case (cmd_q)
					CMD_ENQ: begin
						if (out_free) begin
							load    = 1'b1;
							state_n = ST_IDLE;
							priority if (empty_q) begin
								mem_req.we = 1'b1;
								head_n     = '0;
								tail_n     = '0;
								empty_n    = 1'b0;
							end else if (tail_inc >= usable
									|| tail_inc >= CNT_W'(DEPTH)) begin
								ld_status = STAT_OVERFLOW;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = tail_inc[IDX_W-1:0];
								tail_n        = tail_inc[IDX_W-1:0];
							end
						end
					end
					CMD_DEQ: begin
						if (out_free) begin
							load    = 1'b1;
							state_n = ST_IDLE;
							priority if (empty_q) begin
								ld_status = STAT_EMPTY;
							end else if (head_q == tail_q) begin
								ld_data = rdata;
								head_n  = '0;
								tail_n  = '0;
								empty_n = 1'b1;
							end else begin
								ld_data = rdata;
								head_n  = head_q + IDX_W'(1);
							end
						end
					end
					CMD_SRCH: begin
						priority if (empty_q) begin
							if (out_free) begin
								load      = 1'b1;
								ld_status = STAT_NOT_FOUND;
								state_n   = ST_IDLE;
							end
						end else if (ptr_q != tail_q) begin
							cnt_en = 1'b1;
							ptr_n  = ptr_q + IDX_W'(1);
						end else if (out_free) begin
							load      = 1'b1;
							ld_count  = total;
							ld_status = (total != '0) ? STAT_FOUND : STAT_NOT_FOUND;
							state_n   = ST_IDLE;
						end
					end
					CMD_DISP: begin
						priority if (empty_q) begin
							if (out_free) begin
								load      = 1'b1;
								ld_status = STAT_EMPTY;
								state_n   = ST_IDLE;
							end
						end else if (out_free) begin
							load    = 1'b1;
							ld_data = rdata;
							ld_last = (ptr_q == tail_q);
							if (ptr_q == tail_q) begin
								state_n = ST_IDLE;
							end else begin
								ptr_n = ptr_q + IDX_W'(1);
							end
						end
					end
					default: begin
						state_n = ST_IDLE;
					end
				endcase
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase

		// Read ahead at the slot the next cycle looks at
		mem_req.raddr = ptr_n;
	end

	// Control state and capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ptr_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			empty_q    <= 1'b1;
			cap_q      <= CAP_RESET;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			ptr_q   <= ptr_n;
			head_q  <= head_n;
			tail_q  <= tail_n;
			empty_q <= empty_n;
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Command payload and result register
	always_ff @(posedge clk) begin
		cmd_q <= cmd_n;
		key_q <= key_n;
		if (load) begin
			out_data_q   <= ld_data;
			out_count_q  <= ld_count;
			out_status_q <= ld_status;
			out_last_q   <= ld_last;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign out_data   = out_data_q;
	assign out_count  = out_count_q;
	assign out_status = out_status_q;
	assign out_last   = out_last_q;

	// An empty queue has both pointers at slot zero
	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0 && tail_q == '0))
		else $error("empty queue with pointers off slot zero");

	// Head never passes tail while entries are held
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> head_q <= tail_q)
		else $error("head passed tail");

	// A walk stays between head and tail
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BUSY && !empty_q && (cmd_q == CMD_SRCH || cmd_q == CMD_DISP))
		|-> (ptr_q >= head_q && ptr_q <= tail_q))
		else $error("walk pointer out of range");

	// A result is loaded only when the output slot is free
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready) |-> !load)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

### src/linear_array_queue_with_search_top.sv
// Top level of the linear array queue with search.
//
// Input stream: s_tuser carries the command (enqueue, dequeue, search,
// display), s_tdata the value to enqueue or the search key. One item is
// taken when s_tvalid and s_tready are high; s_tready is high only while
// the sequencer is idle.
// Output stream: each result carries status in m_tuser, the dequeued or
// displayed value and the match count in m_tdata, and m_tlast on the final
// result of a command.
// Walks: search and display step from head to tail through the single read
// port of the entry store, one slot a cycle; search checks each slot in the
// compare unit, and display steps only while the result register is free.
// On an empty queue either gives a single result. The next item is taken
// while the last result still waits in the output register. When the
// receiver stalls, a display walk holds on its current slot and resumes
// when the result register frees; a search walk waits at its last slot.
// Reset empties the queue and sets capacity to the full depth; the entry
// store is not cleared. cfg_we writes capacity; write it only while idle.
`default_nettype none

module linear_array_queue_with_search_top
	import laq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CAP_W-1:0]  cfg_wdata,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [31:0]       s_tdata,   // [31:0] value
	input  wire logic [1:0]        s_tuser,   // [1:0] command
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [39:0]            m_tdata,   // [31:0] data, [36:32] match_count, zero fill
	output logic [2:0]             m_tuser,   // [2:0] status
	output logic                   m_tlast
);

	mem_req_t          mem_req;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] out_data;
	logic [CNT_W-1:0]  out_count;

	laq_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	laq_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.out_data   (out_data),
		.out_count  (out_count),
		.out_status (m_tuser),
		.out_last   (m_tlast),
		.mem_req    (mem_req),
		.rdata      (rdata)
	);

	// Pack result fields, lowest first
	assign m_tdata = {3'b000, out_count, out_data};

endmodule

`default_nettype wire
